### rtl/mlqs_pkg.sv
// ----------------------------------------------------------------------------
// mlqs_pkg
// Shared types, field widths and codes of the multilevel queue scheduler.
// ----------------------------------------------------------------------------
package mlqs_pkg;

	localparam int QUEUE_SLOTS_DEF = 8;
	localparam int MAX_QUEUES_DEF  = 8;

	localparam int OP_W     = 2;
	localparam int QIDX_W   = 3;
	localparam int ID_W     = 8;
	localparam int PRIO_W   = 8;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 4;

	// any dequeue code that is not the priority one is served in fifo order
	localparam logic [OP_W-1:0] OP_ENQ      = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQ_PRIO = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic start;
		logic rd_valid;
	} best_ctl_t;

endpackage

### rtl/mlqs_if.sv
// ----------------------------------------------------------------------------
// mlqs_req_if / mlqs_rsp_if
// Valid/ready channels for scheduler requests and results.
// ----------------------------------------------------------------------------
interface mlqs_req_if;
	logic                          valid;
	logic                          ready;
	logic [mlqs_pkg::OP_W-1:0]     operation;
	logic [mlqs_pkg::QIDX_W-1:0]   queue_index;
	logic [mlqs_pkg::ID_W-1:0]     process_id;
	logic [mlqs_pkg::PRIO_W-1:0]   entry_priority;

	modport source (output valid, operation, queue_index, process_id, entry_priority,
		input ready);
	modport sink (input valid, operation, queue_index, process_id, entry_priority,
		output ready);
endinterface

interface mlqs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [mlqs_pkg::STATUS_W-1:0] status;
	logic [mlqs_pkg::ID_W-1:0]     served_id;
	logic [mlqs_pkg::PRIO_W-1:0]   served_priority;
	logic [mlqs_pkg::QIDX_W-1:0]   served_queue;

	modport source (output valid, status, served_id, served_priority, served_queue,
		input ready);
	modport sink (input valid, status, served_id, served_priority, served_queue,
		output ready);
endinterface

### rtl/mlqs_entry_ram.sv
// ----------------------------------------------------------------------------
// mlqs_entry_ram
// Entry store of all queues: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mlqs_entry_ram import mlqs_pkg::*; #(
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/mlqs_best_unit.sv
// ----------------------------------------------------------------------------
// mlqs_best_unit
// Shared priority comparator: tracks the first highest-priority entry of a
// scan, and keeps the head entry for the swap.
// ----------------------------------------------------------------------------
module mlqs_best_unit import mlqs_pkg::*; #(
	parameter int SLOT_W = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  best_ctl_t         ctl,
	input  logic [SLOT_W-1:0] rd_slot,
	input  entry_t            rd_entry,
	output logic [SLOT_W-1:0] best_slot,
	output entry_t            best_entry,
	output entry_t            head_entry
);

	logic              first_q;
	logic [SLOT_W-1:0] best_slot_q;
	entry_t            best_entry_q;
	entry_t            head_entry_q;
	logic              take;

	// strict compare keeps the earliest entry on ties
	assign take = ctl.rd_valid && (first_q || (rd_entry.prio > best_entry_q.prio));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (ctl.start) begin
			first_q <= 1'b1;
		end else if (ctl.rd_valid) begin
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_slot_q  <= rd_slot;
			best_entry_q <= rd_entry;
		end
		if (ctl.rd_valid && first_q) begin
			head_entry_q <= rd_entry;
		end
	end

	assign best_slot  = best_slot_q;
	assign best_entry = best_entry_q;
	assign head_entry = head_entry_q;

endmodule

### rtl/multilevel_queue_scheduler_core.sv
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler_core
// Ring-buffer queues with enqueue, fifo dequeue and highest-priority dequeue.
// ----------------------------------------------------------------------------
//   channel  dir  handshake      payload
//   req      in   valid/ready    operation, queue_index, process_id, entry_priority
//   rsp      out  valid/ready    status, served_id, served_priority, served_queue
//   cfg      in   cfg_we         cfg_wdata (queue_count)
//
// one request at a time: an enqueue steps S_SELECT, S_ENQ, S_DONE (no S_ENQ on a
// bad index), a dequeue S_SELECT, S_START, S_SCAN, S_SWAP, S_DONE (S_SELECT, S_DONE
// when every queue is empty), reading the head entry only in fifo mode and up to
// QUEUE_SLOTS-1 entries in priority mode through the single read port of the entry
// store and the one priority comparator. arst_n clears all pointers and the queue
// count; the entry store is not cleared. a stalled rsp holds the sequencer in its
// last state while req is not ready; a new request is taken while a result waits.
// ----------------------------------------------------------------------------
module multilevel_queue_scheduler_core import mlqs_pkg::*; #(
	parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
	parameter int MAX_QUEUES  = MAX_QUEUES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	mlqs_req_if.sink         req,
	mlqs_rsp_if.source       rsp
);

	localparam int SW = $clog2(QUEUE_SLOTS);
	localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
	localparam int CW = $clog2(MAX_QUEUES + 1);
	localparam int AW = QW + SW;
	localparam logic [SW-1:0] LAST_SLOT = SW'(QUEUE_SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SELECT, S_ENQ, S_START, S_SCAN, S_SWAP, S_DONE
	} state_t;

	state_t                state_q;
	logic                  op_enq_q;
	logic                  op_prio_q;
	logic                  bad_q;
	entry_t                new_entry_q;
	logic [QW-1:0]         cur_q_q;
	logic [SW-1:0]         head_q [MAX_QUEUES];
	logic [SW-1:0]         tail_q [MAX_QUEUES];
	logic [CW-1:0]         queue_count_q;
	logic [SW-1:0]         issue_slot_q;
	logic [SW-1:0]         scan_end_q;
	logic                  rd_pend_q;
	logic [SW-1:0]         rd_slot_q;
	logic [STATUS_W-1:0]   res_status_q;
	entry_t                res_entry_q;
	logic                  rsp_valid_q;
	logic [STATUS_W-1:0]   rsp_status_q;
	entry_t                rsp_entry_q;
	logic [QIDX_W-1:0]     rsp_queue_q;

	logic [SW-1:0]         cur_head;
	logic [SW-1:0]         cur_tail;
	logic                  cur_full;
	logic [MAX_QUEUES-1:0] nonempty;
	logic                  cand_any;
	logic [QW-1:0]         cand_idx;
	logic                  scan_issue;
	logic [CW-1:0]         count_sat;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	entry_t                ram_wdata;
	logic [AW-1:0]         ram_raddr;
	entry_t                ram_rdata;

	best_ctl_t             best_ctl;
	logic [SW-1:0]         best_slot;
	entry_t                best_entry;
	entry_t                head_entry;

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] p);
		next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	assign cur_head = head_q[cur_q_q];
	assign cur_tail = tail_q[cur_q_q];
	assign cur_full = (next_slot(cur_tail) == cur_head);

	for (genvar g = 0; g < MAX_QUEUES; g++) begin : g_empty
		assign nonempty[g] = (head_q[g] != tail_q[g]);
	end

	// lowest-numbered queue in use that holds an entry
	always_comb begin
		cand_any = 1'b0;
		cand_idx = '0;
		for (int i = MAX_QUEUES - 1; i >= 0; i--) begin
			if ((i < int'(queue_count_q)) && nonempty[i]) begin
				cand_any = 1'b1;
				cand_idx = QW'(i);
			end
		end
	end

	assign count_sat = (int'(cfg_wdata) > MAX_QUEUES) ? CW'(MAX_QUEUES) : CW'(cfg_wdata);

	assign scan_issue = (state_q == S_SCAN) && (issue_slot_q != scan_end_q);

	always_comb begin
		ram_we    = ((state_q == S_ENQ) && !cur_full) || (state_q == S_SWAP);
		ram_waddr = (state_q == S_SWAP) ? {cur_q_q, best_slot} : {cur_q_q, cur_tail};
		ram_wdata = (state_q == S_SWAP) ? head_entry : new_entry_q;
		ram_raddr = {cur_q_q, issue_slot_q};
	end

	assign best_ctl.start    = (state_q == S_START);
	assign best_ctl.rd_valid = rd_pend_q;

	mlqs_entry_ram #(
		.AW(AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mlqs_best_unit #(
		.SLOT_W(SW)
	) u_best (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (best_ctl),
		.rd_slot    (rd_slot_q),
		.rd_entry   (ram_rdata),
		.best_slot  (best_slot),
		.best_entry (best_entry),
		.head_entry (head_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			queue_count_q <= '0;
			rd_pend_q     <= 1'b0;
			rsp_valid_q   <= 1'b0;
			for (int i = 0; i < MAX_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			// in S_DONE the result register is loaded below instead
			if (rsp_valid_q && rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end

			// one read in flight per cycle, its data lands in the best unit
			rd_pend_q <= scan_issue;
			if (scan_issue) begin
				rd_slot_q    <= issue_slot_q;
				issue_slot_q <= next_slot(issue_slot_q);
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_enq_q    <= (req.operation == OP_ENQ);
						op_prio_q   <= (req.operation == OP_DEQ_PRIO);
						bad_q       <= (int'(req.queue_index) >= int'(queue_count_q));
						cur_q_q     <= QW'(req.queue_index);
						new_entry_q <= '{id: req.process_id, prio: req.entry_priority};
						res_entry_q <= '0;
						state_q     <= S_SELECT;
					end
				end
				S_SELECT: begin
					if (op_enq_q) begin
						if (bad_q) begin
							res_status_q <= ST_BAD_INDEX;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_ENQ;
						end
					end else if (!cand_any) begin
						res_status_q <= ST_EMPTY;
						state_q      <= S_DONE;
					end else begin
						cur_q_q <= cand_idx;
						state_q <= S_START;
					end
				end
				S_ENQ: begin
					if (cur_full) begin
						res_status_q <= ST_FULL;
					end else begin
						res_status_q      <= ST_OK;
						tail_q[cur_q_q]   <= next_slot(cur_tail);
					end
					state_q <= S_DONE;
				end
				S_START: begin
					// fifo mode reads the head entry only
					issue_slot_q <= cur_head;
					scan_end_q   <= op_prio_q ? cur_tail : next_slot(cur_head);
					state_q      <= S_SCAN;
				end
				S_SCAN: begin
					if (!scan_issue && !rd_pend_q) begin
						state_q <= S_SWAP;
					end
				end
				S_SWAP: begin
					head_q[cur_q_q] <= next_slot(cur_head);
					res_status_q    <= ST_OK;
					res_entry_q     <= best_entry;
					state_q         <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_entry_q  <= res_entry_q;
						rsp_queue_q  <= ((res_status_q == ST_OK) && !op_enq_q) ?
							QIDX_W'(cur_q_q) : '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// queue_count write empties every queue
			if (cfg_we) begin
				queue_count_q <= count_sat;
				for (int i = 0; i < MAX_QUEUES; i++) begin
					head_q[i] <= '0;
					tail_q[i] <= '0;
				end
			end
		end
	end

	assign req.ready           = (state_q == S_IDLE);
	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.served_id       = rsp_entry_q.id;
	assign rsp.served_priority = rsp_entry_q.prio;
	assign rsp.served_queue    = rsp_queue_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while previous one in progress");

	a_cfg_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (nonempty == '0))
		else $error("queues not empty after queue_count write");

	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |=> ((state_q == S_SCAN) || (state_q == S_SWAP)))
		else $error("scan left to an unexpected state");

	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ST_OK)) |->
		((rsp.served_id == '0) && (rsp.served_priority == '0) && (rsp.served_queue == '0)))
		else $error("served fields set on a failed request");

endmodule

### tb/multilevel_queue_scheduler_core_tb.sv
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler_core_tb
// Sends enqueue and dequeue requests to the scheduler under several queue
// counts and handshake idling patterns. A behavioral copy of the queues works
// out each result, and the results are compared in order, field by field.
// ----------------------------------------------------------------------------
module multilevel_queue_scheduler_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mlqs_pkg::*;

	localparam logic [OP_W-1:0] OP_DEQ_FIFO  = 2'd1;
	localparam logic [OP_W-1:0] OP_DEQ_SPARE = 2'd3;

	localparam int SLOT_W = $clog2(QUEUE_SLOTS_DEF);

	localparam logic [CFG_W-1:0] PHASE_COUNTS [8] =
		'{4'd8, 4'd1, 4'd15, 4'd4, 4'd2, 4'd6, 4'd0, 4'd12};

	typedef logic [SLOT_W-1:0] slot_idx_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [QIDX_W-1:0] queue_index;
		logic [ID_W-1:0]   process_id;
		logic [PRIO_W-1:0] entry_priority;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     served_id;
		logic [PRIO_W-1:0]   served_priority;
		logic [QIDX_W-1:0]   served_queue;
	} outcome_t;

	class queue_tracker;
		entry_t      slots [MAX_QUEUES_DEF][QUEUE_SLOTS_DEF];
		slot_idx_t   head_ptr [MAX_QUEUES_DEF];
		slot_idx_t   tail_ptr [MAX_QUEUES_DEF];
		int unsigned queues_in_use;
		outcome_t    pending_outcomes [$];
		int unsigned error_count;
		int unsigned results_checked;
		int unsigned status_seen [4];

		function new();
			queues_in_use   = 0;
			error_count     = 0;
			results_checked = 0;
			foreach (status_seen[i])
				status_seen[i] = 0;
			clear_pointers();
		endfunction

		function void clear_pointers();
			foreach (head_ptr[i]) begin
				head_ptr[i] = '0;
				tail_ptr[i] = '0;
			end
		endfunction

		function void set_queue_count(logic [CFG_W-1:0] value);
			queues_in_use = (value > MAX_QUEUES_DEF) ? MAX_QUEUES_DEF : value;
			clear_pointers();
		endfunction

		function int unsigned outstanding();
			return pending_outcomes.size();
		endfunction

		function slot_idx_t next_slot(slot_idx_t s);
			return s + slot_idx_t'(1);
		endfunction

		function outcome_t predict_outcome(request_t r);
			outcome_t  o;
			slot_idx_t h, t, best, j;
			entry_t    swap;
			int        q;
			o        = '0;
			o.status = ST_OK;
			if (r.operation == OP_ENQ) begin
				if (r.queue_index >= queues_in_use) begin
					o.status = ST_BAD_INDEX;
					return o;
				end
				t = tail_ptr[r.queue_index];
				if (next_slot(t) == head_ptr[r.queue_index]) begin
					o.status = ST_FULL;
					return o;
				end
				slots[r.queue_index][t] = '{id: r.process_id, prio: r.entry_priority};
				tail_ptr[r.queue_index] = next_slot(t);
				return o;
			end
			for (q = 0; q < queues_in_use; q++) begin
				h = head_ptr[q];
				t = tail_ptr[q];
				if (h == t)
					continue;
				if (r.operation == OP_DEQ_PRIO) begin
					// strict compare keeps the earliest of equal priorities
					best = h;
					j    = next_slot(h);
					while (j != t) begin
						if (slots[q][j].prio > slots[q][best].prio)
							best = j;
						j = next_slot(j);
					end
					swap           = slots[q][h];
					slots[q][h]    = slots[q][best];
					slots[q][best] = swap;
				end
				o.served_id       = slots[q][h].id;
				o.served_priority = slots[q][h].prio;
				o.served_queue    = QIDX_W'(q);
				head_ptr[q]       = next_slot(h);
				return o;
			end
			o.status = ST_EMPTY;
			return o;
		endfunction

		function void note_request(request_t r);
			outcome_t o;
			o = predict_outcome(r);
			pending_outcomes.push_back(o);
			status_seen[o.status]++;
		endfunction

		task report_mismatch(string what);
			$display("%0t ns  mismatch: %s", $time, what);
			error_count++;
		endtask

		task check_outcome(outcome_t got);
			outcome_t want;
			results_checked++;
			if (pending_outcomes.size() == 0) begin
				report_mismatch($sformatf("result beat with none outstanding, status %0d",
					got.status));
				return;
			end
			want = pending_outcomes.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
			if (got.served_id !== want.served_id)
				report_mismatch($sformatf("served_id %0h, wanted %0h",
					got.served_id, want.served_id));
			if (got.served_priority !== want.served_priority)
				report_mismatch($sformatf("served_priority %0h, wanted %0h",
					got.served_priority, want.served_priority));
			if (got.served_queue !== want.served_queue)
				report_mismatch($sformatf("served_queue %0d, wanted %0d",
					got.served_queue, want.served_queue));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	int unsigned send_idle_pct;
	int unsigned rsp_idle_pct;
	int unsigned settings_used;
	bit          stall_request = 1'b0;

	queue_tracker tracker = new();

	mlqs_req_if req_ch ();
	mlqs_rsp_if rsp_ch ();

	multilevel_queue_scheduler_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random backpressure, plus one long hold-off on request
	initial begin : rsp_driver
		int unsigned hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request <= 1'b0;
				hold_left = 300;
			end
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && req_ch.valid && req_ch.ready)
			tracker.note_request(request_t'({req_ch.operation, req_ch.queue_index,
				req_ch.process_id, req_ch.entry_priority}));
		if (arst_n === 1'b1 && rsp_ch.valid && rsp_ch.ready)
			tracker.check_outcome(outcome_t'({rsp_ch.status, rsp_ch.served_id,
				rsp_ch.served_priority, rsp_ch.served_queue}));
	end

	function automatic request_t enq(logic [QIDX_W-1:0] qi, logic [ID_W-1:0] pid,
		logic [PRIO_W-1:0] pri);
		return '{operation: OP_ENQ, queue_index: qi, process_id: pid, entry_priority: pri};
	endfunction

	function automatic request_t deq(logic [OP_W-1:0] op);
		return '{operation: op, queue_index: QIDX_W'($urandom_range(7)),
			process_id: ID_W'($urandom_range(255)), entry_priority: PRIO_W'($urandom_range(255))};
	endfunction

	function automatic request_t random_request(int unsigned enq_pct, int unsigned span);
		request_t    r;
		int unsigned a, b;
		r = deq(OP_DEQ_FIFO);
		if ($urandom_range(3) == 0)
			r.entry_priority = PRIO_W'($urandom_range(3));	// crowd priorities for ties
		if ($urandom_range(99) < enq_pct) begin
			r.operation = OP_ENQ;
			// mostly queues in use, biased low so the first ones fill up
			if (span != 0 && $urandom_range(9) != 0) begin
				a = $urandom_range(span - 1);
				b = $urandom_range(span - 1);
				r.queue_index = QIDX_W'((a < b) ? a : b);
			end
		end else begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: r.operation = OP_DEQ_PRIO;
				6, 7, 8:          r.operation = OP_DEQ_FIFO;
				default:          r.operation = OP_DEQ_SPARE;
			endcase
		end
		return r;
	endfunction

	task automatic send_request(input request_t r);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.operation      <= r.operation;
		req_ch.queue_index    <= r.queue_index;
		req_ch.process_id     <= r.process_id;
		req_ch.entry_priority <= r.entry_priority;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// only once every result is back, so the block sits idle
	task automatic write_queue_count(input logic [CFG_W-1:0] value);
		req_ch.valid <= 1'b0;
		// let the monitor note the last accepted beat first
		@(posedge clk);
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_queue_count(value);
		settings_used++;
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] count_value, input int unsigned items,
		input bit squeeze);
		int unsigned span, enq_pct, sent;
		write_queue_count(count_value);
		span    = tracker.queues_in_use;
		enq_pct = 50;
		for (sent = 0; sent < items; sent++) begin
			if (sent % 16 == 0) begin
				case ($urandom_range(3))
					0:       enq_pct = 25;
					1:       enq_pct = 50;
					2:       enq_pct = 70;
					default: enq_pct = 90;
				endcase
			end
			if (squeeze && sent == 8)
				stall_request <= 1'b1;
			send_request(random_request(enq_pct, span));
		end
	endtask

	initial begin
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_wdata             <= '0;
		req_ch.valid          <= 1'b0;
		req_ch.operation      <= OP_ENQ;
		req_ch.queue_index    <= '0;
		req_ch.process_id     <= '0;
		req_ch.entry_priority <= '0;
		settings_used = 0;
		send_idle_pct = 23;
		rsp_idle_pct  = 83;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// no queues in use after reset
		send_request(enq(3'd0, 8'h12, 8'h34));
		send_request(deq(OP_DEQ_FIFO));

		// oversized count saturates; fill the last queue past full
		write_queue_count(4'd15);
		send_request(enq(3'd7, 8'hFF, 8'h00));
		send_request(enq(3'd7, 8'h00, 8'hFF));
		send_request(enq(3'd7, 8'hA5, 8'h80));
		send_request(enq(3'd7, 8'h5A, 8'hFF));
		send_request(enq(3'd7, 8'h11, 8'h10));
		send_request(enq(3'd7, 8'h22, 8'h7F));
		send_request(enq(3'd7, 8'h33, 8'h01));
		send_request(enq(3'd7, 8'h44, 8'h44));
		send_request(deq(OP_DEQ_PRIO));
		send_request(deq(OP_DEQ_PRIO));
		send_request(deq(OP_DEQ_SPARE));
		send_request(deq(OP_DEQ_FIFO));
		send_request(enq(3'd0, 8'h3C, 8'hC3));
		send_request(deq(OP_DEQ_FIFO));

		write_queue_count(4'd3);
		send_request(enq(3'd3, 8'h77, 8'h88));
		send_request(enq(3'd2, 8'hC3, 8'h3C));
		send_request(deq(OP_DEQ_PRIO));
		send_request(deq(OP_DEQ_PRIO));

		for (int p = 0; p < 8; p++) begin
			if (p == 3) begin
				send_idle_pct = 83;
				rsp_idle_pct  = 23;
			end
			if (p == 6) begin
				send_idle_pct = 0;
				rsp_idle_pct  = 0;
			end
			run_phase(PHASE_COUNTS[p], (PHASE_COUNTS[p] == 0) ? 30 : 120, p == 7);
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d results over %0d queue count settings, fifo and priority dequeues",
			tracker.results_checked, settings_used);
		$display("statuses: %0d ok, %0d full, %0d bad index, %0d empty; %0d mismatches",
			tracker.status_seen[ST_OK], tracker.status_seen[ST_FULL],
			tracker.status_seen[ST_BAD_INDEX], tracker.status_seen[ST_EMPTY],
			tracker.error_count);
		if (tracker.error_count == 0) begin
			$display("multilevel_queue_scheduler_core_tb: done, clean");
		end else begin
			$display("multilevel_queue_scheduler_core_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("multilevel_queue_scheduler_core_tb: timeout, %0d results outstanding",
			tracker.outstanding());
		$display("multilevel_queue_scheduler_core_tb: done, errors");
		$finish;
	end

endmodule

### sim.f
rtl/mlqs_pkg.sv
rtl/mlqs_if.sv
rtl/mlqs_entry_ram.sv
rtl/mlqs_best_unit.sv
rtl/multilevel_queue_scheduler_core.sv
tb/multilevel_queue_scheduler_core_tb.sv
